// ===== rtl/gcg_pkg.sv =====
`default_nettype none

package gcg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_TEMP_LIMITS = 3'd1,
        CFG_UTIL_LIMITS = 3'd2,
        CFG_CLOCK_LIMIT = 3'd3,
        CFG_STEP_RATIOS = 3'd4,
        CFG_WINDOW      = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_OVERTEMP  = 3'd1,
        RSN_LOW_LOAD  = 3'd2,
        RSN_HIGH_LOAD = 3'd3,
        RSN_UNLOCK    = 3'd4
    } t_reason;

    typedef enum logic [1:0] {
        UP_AGGR = 2'd0,
        UP_STEP = 2'd1,
        UP_KEEP = 2'd2,
        UP_DOWN = 2'd3
    } t_up_mode;

    localparam int VOTE_DOWN   = 0;
    localparam int VOTE_UP     = 1;
    localparam int VOTE_UNLOCK = 2;
    localparam int NUM_VOTES   = 3;

    localparam int WINDOW_MIN = 3;

    localparam logic [11:0] CLK_MAX    = 12'd4095;
    localparam logic [13:0] ROUND_HALF = 14'd5;

    // floor(p / 100) = (p * DIV100_MULT) >> DIV100_SHIFT, exact for p below 2^20.
    localparam logic [20:0] DIV100_MULT  = 21'd1342178;
    localparam int          DIV100_SHIFT = 27;
    // floor(x / 10) = (x * DIV10_MULT) >> DIV10_SHIFT, exact for x below 2^14.
    localparam logic [14:0] DIV10_MULT   = 15'd26215;
    localparam int          DIV10_SHIFT  = 18;

endpackage

`default_nettype wire

// ===== rtl/gpu_clock_governor.sv =====
// GPU clock governor.
// Samples (current clock, utilisation, temperature) enter on a valid/ready channel
// and each produces exactly one result (target clock, reason code, lock flag) on a
// valid/ready output channel. Configuration registers are written through a plain
// write port (enable, index, data), by the user only while no transaction is in
// flight; the block itself does not enforce this. One sample can be accepted every
// cycle while results are taken and no recount runs: the clock scaling runs through
// four registered stages (product, divide by 100, divide by 10, round and clamp),
// and the vote windows with their running hit counts are updated in the final
// stage, one sample per cycle, while enabled. When the receiver stalls, the output
// register holds its result and the stages behind it keep filling; ready falls only
// once every stage is occupied. Reset clears all vote histories and the lock flag
// and restores the register defaults (window 3, everything else zero). A write to
// the window register trims the histories to the new window and then recounts their
// hits, one bit position a cycle; no sample is accepted during that recount.
`default_nettype none

module gpu_clock_governor #(
    parameter int WINDOW_MAX = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gcg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [11:0]                      i_current_clock,
    input  logic [6:0]                       i_utilisation,
    input  logic [7:0]                       i_temperature,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [11:0]                      o_target_clock,
    output logic [2:0]                       o_reason_code,
    output logic                             o_locked
);

    import gcg_pkg::*;

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int IW = $clog2(WINDOW_MAX);
    localparam int VW = CW + 3;

    function automatic logic [CW-1:0] eff_window(input logic [5:0] v);
        logic [CW-1:0] w;
        if (int'(v) < WINDOW_MIN) begin
            w = CW'(WINDOW_MIN);
        end else if (int'(v) > WINDOW_MAX) begin
            w = CW'(WINDOW_MAX);
        end else begin
            w = CW'(v);
        end
        return w;
    endfunction

    function automatic logic [WINDOW_MAX-1:0] window_mask(input logic [CW-1:0] w);
        logic [WINDOW_MAX-1:0] m;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            m[k] = (k < int'(w));
        end
        return m;
    endfunction

    // Configuration registers.
    logic        r_enable;
    logic [23:0] r_temp_lim;
    logic [23:0] r_util_lim;
    logic [47:0] r_clock_lim;
    logic [23:0] r_ratios;
    logic [5:0]  r_window;

    logic [7:0]  cool_t, raise_t, protect_t;
    logic [7:0]  idle_u, low_u, high_u;
    logic [11:0] floor_mhz, ceil_mhz, gate_mhz, unlock_mhz;
    logic [7:0]  down_ratio, up_ratio, aggr_ratio;

    assign cool_t     = r_temp_lim[7:0];
    assign raise_t    = r_temp_lim[15:8];
    assign protect_t  = r_temp_lim[23:16];
    assign idle_u     = r_util_lim[7:0];
    assign low_u      = r_util_lim[15:8];
    assign high_u     = r_util_lim[23:16];
    assign floor_mhz  = r_clock_lim[11:0];
    assign ceil_mhz   = r_clock_lim[23:12];
    assign gate_mhz   = r_clock_lim[35:24];
    assign unlock_mhz = r_clock_lim[47:36];
    assign down_ratio = r_ratios[7:0];
    assign up_ratio   = r_ratios[15:8];
    assign aggr_ratio = r_ratios[23:16];

    // Vote state.
    logic [WINDOW_MAX-1:0] r_bits [NUM_VOTES];
    logic [CW-1:0]         r_fill [NUM_VOTES];
    logic [CW-1:0]         r_hits [NUM_VOTES];
    logic                  r_lock;
    logic                  r_sweep;
    logic [IW-1:0]         r_sweep_idx;

    // Pipeline registers.
    logic        r0_valid, r1_valid, r2_valid, r3_valid, r4_valid, r_out_valid;
    logic [11:0] r0_clk, r1_clk, r2_clk, r3_clk, r4_clk;
    logic [6:0]  r0_util, r1_util, r2_util, r3_util, r4_util;
    logic [7:0]  r0_temp, r1_temp, r2_temp, r3_temp, r4_temp;
    t_up_mode    r1_mode, r2_mode, r3_mode;
    logic [19:0] r1_p_dn, r1_p_up;
    logic [13:0] r2_x_dn, r2_x_up;
    logic [10:0] r3_q_dn, r3_q_up;
    logic [11:0] r4_sc_dn, r4_sc_up;
    logic [11:0] r_target;
    t_reason     r_reason;
    logic        r_locked;

    logic take_out, take4, take3, take2, take1, take0, step;

    assign take_out   = !r_out_valid || i_out_ready;
    assign take4      = !r4_valid || take_out;
    assign take3      = !r3_valid || take4;
    assign take2      = !r2_valid || take3;
    assign take1      = !r1_valid || take2;
    assign take0      = !r0_valid || take1;
    assign o_in_ready = take0 && !r_sweep;
    assign step       = r4_valid && take_out;

    // Stage 0: ratio choice for the scale-up path and both products.
    t_up_mode    s0_mode;
    logic [7:0]  s0_up_ratio;
    logic [19:0] s0_p_dn, s0_p_up;

    always_comb begin
        if ({1'b0, r0_util} >= low_u && r0_temp <= cool_t) begin
            s0_mode = UP_AGGR;
        end else if (r0_temp <= raise_t) begin
            s0_mode = UP_STEP;
        end else if (r0_temp <= protect_t) begin
            s0_mode = UP_KEEP;
        end else begin
            s0_mode = UP_DOWN;
        end
        s0_up_ratio = (s0_mode == UP_AGGR) ? aggr_ratio : up_ratio;
        s0_p_dn = {8'b0, r0_clk} * {12'b0, down_ratio};
        s0_p_up = {8'b0, r0_clk} * {12'b0, s0_up_ratio};
    end

    // Stage 1: divide by 100 and add the rounding half.
    logic [40:0] s1_prod_dn, s1_prod_up;
    logic [13:0] s1_x_dn, s1_x_up;

    always_comb begin
        s1_prod_dn = {21'b0, r1_p_dn} * {20'b0, DIV100_MULT};
        s1_prod_up = {21'b0, r1_p_up} * {20'b0, DIV100_MULT};
        s1_x_dn    = s1_prod_dn[DIV100_SHIFT +: 14] + ROUND_HALF;
        s1_x_up    = s1_prod_up[DIV100_SHIFT +: 14] + ROUND_HALF;
    end

    // Stage 2: divide by 10.
    logic [28:0] s2_prod_dn, s2_prod_up;

    always_comb begin
        s2_prod_dn = {15'b0, r2_x_dn} * {14'b0, DIV10_MULT};
        s2_prod_up = {15'b0, r2_x_up} * {14'b0, DIV10_MULT};
    end

    // Stage 3: back to a multiple of 10, then floor, ceiling, saturation and the up-mode choice.
    logic [13:0] s3_g_dn, s3_g_up, s3_gd;
    logic [11:0] s3_sc_dn, s3_sc_up;

    always_comb begin
        s3_g_dn = {r3_q_dn, 3'b0} + {2'b0, r3_q_dn, 1'b0};
        s3_g_up = {r3_q_up, 3'b0} + {2'b0, r3_q_up, 1'b0};
        s3_gd   = (s3_g_dn < {2'b0, floor_mhz}) ? {2'b0, floor_mhz} : s3_g_dn;
        s3_sc_dn = (s3_gd > {2'b0, CLK_MAX}) ? CLK_MAX : s3_gd[11:0];
        case (r3_mode)
            UP_AGGR, UP_STEP: begin
                s3_sc_up = (s3_g_up > {2'b0, ceil_mhz}) ? ceil_mhz : s3_g_up[11:0];
            end
            UP_KEEP: begin
                s3_sc_up = r3_clk;
            end
            default: begin
                s3_sc_up = s3_sc_dn;
            end
        endcase
    end

    // Stage 4: vote windows and the decision.
    logic [CW-1:0]         cur_w;
    logic [WINDOW_MAX-1:0] cur_mask;
    logic [IW-1:0]         oldest_idx;
    logic [NUM_VOTES-1:0]  hit, fire;
    logic [WINDOW_MAX-1:0] p_bits [NUM_VOTES];
    logic [CW-1:0]         p_fill [NUM_VOTES];
    logic [CW-1:0]         p_hits [NUM_VOTES];
    logic [WINDOW_MAX-1:0] n_bits [NUM_VOTES];
    logic [CW-1:0]         n_fill [NUM_VOTES];
    logic [CW-1:0]         n_hits [NUM_VOTES];
    logic                  over_temp, fire_dn, fire_up, fire_ul;
    logic [11:0]           n_target;
    t_reason               n_reason;
    logic                  n_lock;

    assign cur_w      = eff_window(r_window);
    assign cur_mask   = window_mask(cur_w);
    assign oldest_idx = IW'(cur_w - CW'(1));

    always_comb begin
        logic                  full;
        logic                  drop;
        logic [WINDOW_MAX-1:0] shifted;

        over_temp = (r4_temp >= protect_t) && (r4_clk > floor_mhz);
        hit[VOTE_DOWN]   = ({1'b0, r4_util} > idle_u) && ({1'b0, r4_util} < low_u)
                           && (r4_clk > floor_mhz);
        hit[VOTE_UP]     = r_lock && ({1'b0, r4_util} > high_u) && (r4_clk >= gate_mhz);
        hit[VOTE_UNLOCK] = r_lock && ({1'b0, r4_util} < idle_u) && (r4_temp < raise_t);

        for (int h = 0; h < NUM_VOTES; h++) begin
            full      = (r_fill[h] == cur_w);
            shifted   = {r_bits[h][WINDOW_MAX-2:0], hit[h]};
            p_bits[h] = full ? (shifted & cur_mask) : shifted;
            drop      = full && r_bits[h][oldest_idx];
            p_hits[h] = r_hits[h] + CW'(hit[h]) - CW'(drop);
            p_fill[h] = full ? cur_w : r_fill[h] + CW'(1);
            fire[h]   = (p_fill[h] == cur_w)
                        && (((VW'(p_hits[h]) << 2) + VW'(p_hits[h])) >= (VW'(cur_w) << 2));
        end

        fire_dn = fire[VOTE_DOWN];
        fire_up = !fire_dn && fire[VOTE_UP];
        fire_ul = !fire_dn && !fire_up && fire[VOTE_UNLOCK];

        for (int h = 0; h < NUM_VOTES; h++) begin
            n_bits[h] = p_bits[h];
            n_fill[h] = p_fill[h];
            n_hits[h] = p_hits[h];
        end
        if (over_temp || fire_dn || fire_up) begin
            n_bits[VOTE_DOWN] = '0;
            n_fill[VOTE_DOWN] = '0;
            n_hits[VOTE_DOWN] = '0;
            n_bits[VOTE_UP]   = '0;
            n_fill[VOTE_UP]   = '0;
            n_hits[VOTE_UP]   = '0;
        end
        if (over_temp || fire_ul) begin
            n_bits[VOTE_UNLOCK] = '0;
            n_fill[VOTE_UNLOCK] = '0;
            n_hits[VOTE_UNLOCK] = '0;
        end else if (fire_dn || fire_up) begin
            n_bits[VOTE_UNLOCK] = r_bits[VOTE_UNLOCK];
            n_fill[VOTE_UNLOCK] = r_fill[VOTE_UNLOCK];
            n_hits[VOTE_UNLOCK] = r_hits[VOTE_UNLOCK];
        end

        if (!r_enable) begin
            n_target = '0;
            n_reason = RSN_NONE;
        end else if (over_temp) begin
            n_target = r4_sc_dn;
            n_reason = RSN_OVERTEMP;
        end else if (fire_dn) begin
            n_target = r4_sc_dn;
            n_reason = RSN_LOW_LOAD;
        end else if (fire_up) begin
            n_target = r4_sc_up;
            n_reason = RSN_HIGH_LOAD;
        end else if (fire_ul) begin
            n_target = unlock_mhz;
            n_reason = RSN_UNLOCK;
        end else begin
            n_target = '0;
            n_reason = RSN_NONE;
        end
        n_lock = (n_reason != RSN_NONE) ? (n_target != 12'd0) : r_lock;
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_temp_lim  <= '0;
            r_util_lim  <= '0;
            r_clock_lim <= '0;
            r_ratios    <= '0;
            r_window    <= 6'(WINDOW_MIN);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:      r_enable    <= i_cfg_data[0];
                CFG_TEMP_LIMITS: r_temp_lim  <= i_cfg_data[23:0];
                CFG_UTIL_LIMITS: r_util_lim  <= i_cfg_data[23:0];
                CFG_CLOCK_LIMIT: r_clock_lim <= i_cfg_data[47:0];
                CFG_STEP_RATIOS: r_ratios    <= i_cfg_data[23:0];
                CFG_WINDOW:      r_window    <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Vote state: trim on a window write, recount, or update per sample while enabled.
    logic [CW-1:0]         trim_w;
    logic [WINDOW_MAX-1:0] trim_mask;

    assign trim_w    = eff_window(i_cfg_data[5:0]);
    assign trim_mask = window_mask(trim_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < NUM_VOTES; h++) begin
                r_bits[h] <= '0;
                r_fill[h] <= '0;
                r_hits[h] <= '0;
            end
            r_lock      <= 1'b0;
            r_sweep     <= 1'b0;
            r_sweep_idx <= '0;
        end else if (i_cfg_we && i_cfg_idx == CFG_WINDOW) begin
            for (int h = 0; h < NUM_VOTES; h++) begin
                r_bits[h] <= r_bits[h] & trim_mask;
                r_fill[h] <= (r_fill[h] > trim_w) ? trim_w : r_fill[h];
                r_hits[h] <= '0;
            end
            r_sweep     <= 1'b1;
            r_sweep_idx <= '0;
        end else if (r_sweep) begin
            for (int h = 0; h < NUM_VOTES; h++) begin
                r_hits[h] <= r_hits[h] + CW'(r_bits[h][r_sweep_idx]);
            end
            if (r_sweep_idx == IW'(WINDOW_MAX - 1)) begin
                r_sweep <= 1'b0;
            end else begin
                r_sweep_idx <= r_sweep_idx + IW'(1);
            end
        end else if (step && r_enable) begin
            for (int h = 0; h < NUM_VOTES; h++) begin
                r_bits[h] <= n_bits[h];
                r_fill[h] <= n_fill[h];
                r_hits[h] <= n_hits[h];
            end
            r_lock <= n_lock;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid    <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take0) begin
                r0_valid <= i_in_valid && !r_sweep;
            end
            if (take1) begin
                r1_valid <= r0_valid;
            end
            if (take2) begin
                r2_valid <= r1_valid;
            end
            if (take3) begin
                r3_valid <= r2_valid;
            end
            if (take4) begin
                r4_valid <= r3_valid;
            end
            if (take_out) begin
                r_out_valid <= r4_valid;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (take0) begin
            r0_clk  <= i_current_clock;
            r0_util <= i_utilisation;
            r0_temp <= i_temperature;
        end
        if (take1) begin
            r1_clk  <= r0_clk;
            r1_util <= r0_util;
            r1_temp <= r0_temp;
            r1_mode <= s0_mode;
            r1_p_dn <= s0_p_dn;
            r1_p_up <= s0_p_up;
        end
        if (take2) begin
            r2_clk  <= r1_clk;
            r2_util <= r1_util;
            r2_temp <= r1_temp;
            r2_mode <= r1_mode;
            r2_x_dn <= s1_x_dn;
            r2_x_up <= s1_x_up;
        end
        if (take3) begin
            r3_clk  <= r2_clk;
            r3_util <= r2_util;
            r3_temp <= r2_temp;
            r3_mode <= r2_mode;
            r3_q_dn <= s2_prod_dn[DIV10_SHIFT +: 11];
            r3_q_up <= s2_prod_up[DIV10_SHIFT +: 11];
        end
        if (take4) begin
            r4_clk   <= r3_clk;
            r4_util  <= r3_util;
            r4_temp  <= r3_temp;
            r4_sc_dn <= s3_sc_dn;
            r4_sc_up <= s3_sc_up;
        end
        if (step) begin
            r_target <= n_target;
            r_reason <= n_reason;
            r_locked <= n_lock;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target_clock = r_target;
    assign o_reason_code  = r_reason;
    assign o_locked       = r_locked;

    a_hits_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hits[VOTE_DOWN] <= r_fill[VOTE_DOWN]) && (r_hits[VOTE_UP] <= r_fill[VOTE_UP])
        && (r_hits[VOTE_UNLOCK] <= r_fill[VOTE_UNLOCK]))
        else $error("vote hit count exceeds its fill");

    a_fill_within_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[VOTE_DOWN] <= cur_w) && (r_fill[VOTE_UP] <= cur_w)
        && (r_fill[VOTE_UNLOCK] <= cur_w))
        else $error("vote fill exceeds the window");

    a_lock_follows_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reason_code != RSN_NONE) |-> (o_locked == (o_target_clock != 12'd0)))
        else $error("lock flag does not follow the applied clock");

    a_no_reason_no_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reason_code == RSN_NONE) |-> (o_target_clock == 12'd0))
        else $error("clock reported without a reason");

endmodule

`default_nettype wire
